>>> hdl/mkve_pkg.sv
package mkve_pkg;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DEPTH  = 4;

    localparam logic [CFG_ADDR_W-1:0] CFG_FRICTION        = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCROLL_INTERVAL = 1'b1;

    localparam logic [4:0]  FRICTION_RESET        = 5'd1;
    localparam logic [15:0] SCROLL_INTERVAL_RESET = 16'd50;

    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [7:0] KEY_BUTTON_LIMIT = 8'd8;
    localparam logic [7:0] KEY_RIGHT        = 8'd8;
    localparam logic [7:0] KEY_LEFT         = 8'd9;
    localparam logic [7:0] KEY_DOWN         = 8'd10;
    localparam logic [7:0] KEY_UP           = 8'd11;
    localparam logic [7:0] KEY_WHEEL_UP     = 8'd12;
    localparam logic [7:0] KEY_WHEEL_DOWN   = 8'd13;

    localparam logic signed [1:0] WHEEL_UP   = 2'sd1;
    localparam logic signed [1:0] WHEEL_DOWN = -2'sd1;
    localparam logic signed [1:0] WHEEL_NONE = 2'sd0;

    // first field in the highest bits
    typedef struct packed {
        logic signed [1:0] wheel;
        logic signed [3:0] move_y;
        logic signed [3:0] move_x;
        logic [7:0]        buttons;
    } report_t;

    typedef struct packed {
        logic    last;
        report_t rpt;
    } out_item_t;

    typedef struct packed {
        logic [4:0]  friction;
        logic [15:0] scroll_interval;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic dual;
    } push_t;

    // one saturating step of 4 in either direction
    function automatic logic signed [7:0] sat_step(logic signed [7:0] v, logic up);
        logic signed [8:0] s;
        s = up ? ($signed({v[7], v}) + 9'sd4) : ($signed({v[7], v}) - 9'sd4);
        if (s > 9'sd127) begin
            return 8'sd127;
        end else if (s < -9'sd128) begin
            return -8'sd128;
        end
        return s[7:0];
    endfunction

    // scale by (16 - friction)/16, round, saturate, kill small magnitudes
    function automatic logic signed [7:0] decay(logic signed [7:0] v, logic [4:0] friction);
        logic signed [5:0]  factor;
        logic signed [13:0] prod;
        logic signed [13:0] rnd;
        logic signed [9:0]  q;
        logic signed [7:0]  r;
        factor = 6'sd16 - $signed({1'b0, friction});
        prod   = $signed({{6{v[7]}}, v}) * $signed({{8{factor[5]}}, factor});
        rnd    = prod + 14'sd8;
        q      = rnd[13:4];
        if (q > 10'sd127) begin
            r = 8'sd127;
        end else if (q < -10'sd128) begin
            r = -8'sd128;
        end else begin
            r = q[7:0];
        end
        if (r > -8'sd2 && r < 8'sd2) begin
            r = 8'sd0;
        end
        return r;
    endfunction

    // divide by 16 toward zero
    function automatic logic signed [3:0] div16(logic signed [7:0] v);
        logic signed [8:0] t;
        t = v[7] ? ($signed({v[7], v}) + 9'sd15) : $signed({v[7], v});
        return t[7:4];
    endfunction

endpackage

>>> hdl/mouse_keys_velocity_engine.sv
// a tick's reports are registered into the output queue when its transaction is accepted
// throughput: one input transaction per cycle while the output queue has two free slots
// a tick with a due wheel report yields two reports, drained one per cycle at the output while m_tready is high
// reset: aresetn synchronous active low; clears state and queue, friction 1, interval 50
module mouse_keys_velocity_engine #(
    parameter int OUT_DEPTH = mkve_pkg::OUT_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mkve_pkg::IN_DATA_W-1:0]    s_tdata,   // key_code, key_down, time_ms
    input  logic                              s_tuser,   // mode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mkve_pkg::OUT_DATA_W-1:0]   m_tdata,   // buttons, move_x, move_y, wheel
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [mkve_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [mkve_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    mkve_pkg::cfg_t      cfg_reg;
    mkve_pkg::push_t     push;
    mkve_pkg::out_item_t item_a, item_b, out_item;
    logic                in_fire;
    logic                has_room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.friction        <= mkve_pkg::FRICTION_RESET;
            cfg_reg.scroll_interval <= mkve_pkg::SCROLL_INTERVAL_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                mkve_pkg::CFG_FRICTION:        cfg_reg.friction        <= cfg_wdata[4:0];
                mkve_pkg::CFG_SCROLL_INTERVAL: cfg_reg.scroll_interval <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = has_room;
    assign in_fire  = s_tvalid && s_tready;

    mkve_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .mode     (s_tuser),
        .key_code (s_tdata[7:0]),
        .key_down (s_tdata[8]),
        .time_ms  (s_tdata[24:9]),
        .cfg      (cfg_reg),
        .push     (push),
        .item_a   (item_a),
        .item_b   (item_b)
    );

    mkve_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_a    (item_a),
        .push_b    (item_b),
        .has_room  (has_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {(mkve_pkg::OUT_DATA_W - $bits(mkve_pkg::report_t))'(0), out_item.rpt};
    assign m_tlast = out_item.last;

endmodule

>>> hdl/mkve_core.sv
module mkve_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_fire,
    input  logic                   mode,
    input  logic [7:0]             key_code,
    input  logic                   key_down,
    input  logic [15:0]            time_ms,
    input  mkve_pkg::cfg_t         cfg,
    output mkve_pkg::push_t        push,
    output mkve_pkg::out_item_t    item_a,
    output mkve_pkg::out_item_t    item_b
);

    logic [7:0]         button_bits_reg, button_bits_next;
    logic [3:0]         held_dirs_reg, held_dirs_next;
    logic signed [7:0]  vel_x_reg, vel_x_next;
    logic signed [7:0]  vel_y_reg, vel_y_next;
    logic signed [3:0]  rep_x_reg, rep_x_next;
    logic signed [3:0]  rep_y_reg, rep_y_next;
    logic signed [1:0]  scroll_dir_reg, scroll_dir_next;
    logic [15:0]        scroll_due_reg, scroll_due_next;

    logic               wheel_due;
    logic signed [7:0]  vx_a, vx_b, vy_a, vy_b, vx_d, vy_d;
    logic signed [3:0]  mx, my;
    mkve_pkg::out_item_t wheel_item, move_item;

    always_comb begin
        vx_a = held_dirs_reg[0] ? mkve_pkg::sat_step(vel_x_reg, 1'b1) : vel_x_reg;
        vx_b = held_dirs_reg[1] ? mkve_pkg::sat_step(vx_a, 1'b0) : vx_a;
        vy_a = held_dirs_reg[2] ? mkve_pkg::sat_step(vel_y_reg, 1'b1) : vel_y_reg;
        vy_b = held_dirs_reg[3] ? mkve_pkg::sat_step(vy_a, 1'b0) : vy_a;
        vx_d = mkve_pkg::decay(vx_b, cfg.friction);
        vy_d = mkve_pkg::decay(vy_b, cfg.friction);
        mx   = mkve_pkg::div16(vx_d);
        my   = mkve_pkg::div16(vy_d);

        wheel_due = (scroll_dir_reg != mkve_pkg::WHEEL_NONE) && (time_ms >= scroll_due_reg);

        wheel_item.last        = 1'b0;
        wheel_item.rpt.buttons = button_bits_reg;
        wheel_item.rpt.move_x  = rep_x_reg;
        wheel_item.rpt.move_y  = rep_y_reg;
        wheel_item.rpt.wheel   = scroll_dir_reg;

        move_item.last         = 1'b1;
        move_item.rpt.buttons  = button_bits_reg;
        move_item.rpt.move_x   = mx;
        move_item.rpt.move_y   = my;
        move_item.rpt.wheel    = mkve_pkg::WHEEL_NONE;

        item_a     = wheel_due ? wheel_item : move_item;
        item_b     = move_item;
        push.valid = in_fire && (mode == mkve_pkg::MODE_TICK);
        push.dual  = wheel_due;
    end

    always_comb begin
        button_bits_next = button_bits_reg;
        held_dirs_next   = held_dirs_reg;
        vel_x_next       = vel_x_reg;
        vel_y_next       = vel_y_reg;
        rep_x_next       = rep_x_reg;
        rep_y_next       = rep_y_reg;
        scroll_dir_next  = scroll_dir_reg;
        scroll_due_next  = scroll_due_reg;
        if (in_fire) begin
            if (mode == mkve_pkg::MODE_KEY) begin
                if (key_code < mkve_pkg::KEY_BUTTON_LIMIT) begin
                    button_bits_next[key_code[2:0]] = key_down;
                end else if (key_code <= mkve_pkg::KEY_UP) begin
                    held_dirs_next[key_code[1:0]] = key_down;
                end else if (key_code == mkve_pkg::KEY_WHEEL_UP ||
                             key_code == mkve_pkg::KEY_WHEEL_DOWN) begin
                    if (!key_down) begin
                        scroll_dir_next = mkve_pkg::WHEEL_NONE;
                    end else if (key_code == mkve_pkg::KEY_WHEEL_UP) begin
                        scroll_dir_next = mkve_pkg::WHEEL_UP;
                    end else begin
                        scroll_dir_next = mkve_pkg::WHEEL_DOWN;
                    end
                    scroll_due_next = time_ms;
                end
            end else begin
                if (wheel_due) begin
                    scroll_due_next = time_ms + cfg.scroll_interval;
                end
                vel_x_next = vx_d;
                vel_y_next = vy_d;
                rep_x_next = mx;
                rep_y_next = my;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            button_bits_reg <= '0;
            held_dirs_reg   <= '0;
            vel_x_reg       <= '0;
            vel_y_reg       <= '0;
            rep_x_reg       <= '0;
            rep_y_reg       <= '0;
            scroll_dir_reg  <= '0;
            scroll_due_reg  <= '0;
        end else begin
            button_bits_reg <= button_bits_next;
            held_dirs_reg   <= held_dirs_next;
            vel_x_reg       <= vel_x_next;
            vel_y_reg       <= vel_y_next;
            rep_x_reg       <= rep_x_next;
            rep_y_reg       <= rep_y_next;
            scroll_dir_reg  <= scroll_dir_next;
            scroll_due_reg  <= scroll_due_next;
        end
    end

endmodule

>>> hdl/mkve_fifo.sv
module mkve_fifo #(
    parameter int DEPTH = mkve_pkg::OUT_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mkve_pkg::push_t        push,
    input  mkve_pkg::out_item_t    push_a,
    input  mkve_pkg::out_item_t    push_b,
    output logic                   has_room,
    output logic                   out_valid,
    input  logic                   out_ready,
    output mkve_pkg::out_item_t    out_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mkve_pkg::out_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_2;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    function automatic logic [PTR_W-1:0] inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        pop         = out_valid && out_ready;
        wr_ptr_2    = inc(wr_ptr_reg);
        wr_ptr_next = wr_ptr_reg;
        if (push.valid) begin
            wr_ptr_next = push.dual ? inc(wr_ptr_2) : wr_ptr_2;
        end
        rd_ptr_next = pop ? inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg
                    + (push.valid ? (push.dual ? CNT_W'(2) : CNT_W'(1)) : CNT_W'(0))
                    - (pop ? CNT_W'(1) : CNT_W'(0));
    end

    assign has_room  = count_reg <= CNT_W'(DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem_reg[wr_ptr_reg] <= push_a;
            if (push.dual) begin
                mem_reg[wr_ptr_2] <= push_b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/mkve_checker.sv
module mkve_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mkve_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic                              m_tlast
);

    // stalled transaction stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("payload changed while stalled");

    // wheel reports are never final, movement reports carry no wheel
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[17:16] == 2'b00)
        else $error("final report carries a wheel step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[17:16] == 2'b01 || m_tdata[17:16] == 2'b11)
        else $error("non-final report without a wheel step");

    // nothing offered straight after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

endmodule

bind mouse_keys_velocity_engine mkve_checker u_mkve_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
);
